FILE: hw/rtl/mfd_pkg.sv
// package: types, constants and crc helper for the motion frame decoder
`default_nettype none
package mfd_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;

  localparam logic [CfgIndexWidth-1:0] REG_SYNC_FIRST    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_SYNC_SECOND   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_VELOCITY_TYPE = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RESET    = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RESET   = 8'h55;
  localparam logic [7:0] VELOCITY_TYPE_RESET = 8'h01;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [4:0] POS_SYNC_FIRST  = 5'd0;
  localparam logic [4:0] POS_SYNC_SECOND = 5'd1;
  localparam logic [4:0] POS_TYPE        = 5'd2;
  localparam logic [4:0] POS_CRC_START   = 5'd2;
  localparam logic [4:0] POS_CRC_END     = 5'd13;
  localparam logic [4:0] POS_FRAME_BYTES = 5'd16;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] velocity_type;
  } cfg_t;

  typedef struct packed {
    logic        frame_ok;
    logic [31:0] linear_bits;
    logic [31:0] angular_bits;
    logic [7:0]  drive_mode;
    logic [7:0]  sequence_number;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mfd_if.sv
// stream interfaces for frame bytes in and decoded frames out
`default_nettype none
interface mfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mfd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [31:0] linear_bits;
  logic [31:0] angular_bits;
  logic [7:0]  drive_mode;
  logic [7:0]  sequence_number;

  modport source (output valid, output frame_ok, output linear_bits, output angular_bits,
                  output drive_mode, output sequence_number, input ready);
  modport sink (input valid, input frame_ok, input linear_bits, input angular_bits,
                input drive_mode, input sequence_number, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mfd_frame.sv
// frame state: header check, crc, field capture and end-of-frame result
`default_nettype none
module mfd_frame (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            beat,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  input  wire mfd_pkg::cfg_t   cfg,
  output logic                 result_valid,
  output mfd_pkg::result_t     result
);
  import mfd_pkg::*;

  logic [4:0]  byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic        header_match, header_match_next;
  logic [31:0] linear_hold, linear_hold_next;
  logic [31:0] angular_hold, angular_hold_next;
  logic [7:0]  mode_hold, mode_hold_next;
  logic [7:0]  sequence_hold, sequence_hold_next;
  logic [15:0] received_crc, received_crc_next;
  logic        ok;

  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    header_match_next  = header_match;
    linear_hold_next   = linear_hold;
    angular_hold_next  = angular_hold;
    mode_hold_next     = mode_hold;
    sequence_hold_next = sequence_hold;
    received_crc_next  = received_crc;
    if (byte_position < POS_FRAME_BYTES) begin
      if (byte_position == POS_SYNC_FIRST && data_byte != cfg.sync_first) begin
        header_match_next = 1'b0;
      end
      if (byte_position == POS_SYNC_SECOND && data_byte != cfg.sync_second) begin
        header_match_next = 1'b0;
      end
      if (byte_position == POS_TYPE && data_byte != cfg.velocity_type) begin
        header_match_next = 1'b0;
      end
      if (byte_position >= POS_CRC_START && byte_position <= POS_CRC_END) begin
        running_crc_next = crc_byte(running_crc, data_byte);
      end
      case (byte_position)
        5'd4:  linear_hold_next[7:0]     = data_byte;
        5'd5:  linear_hold_next[15:8]    = data_byte;
        5'd6:  linear_hold_next[23:16]   = data_byte;
        5'd7:  linear_hold_next[31:24]   = data_byte;
        5'd8:  angular_hold_next[7:0]    = data_byte;
        5'd9:  angular_hold_next[15:8]   = data_byte;
        5'd10: angular_hold_next[23:16]  = data_byte;
        5'd11: angular_hold_next[31:24]  = data_byte;
        5'd12: mode_hold_next            = data_byte;
        5'd13: sequence_hold_next        = data_byte;
        5'd14: received_crc_next[7:0]    = data_byte;
        5'd15: received_crc_next[15:8]   = data_byte;
        default: ;
      endcase
      byte_position_next = byte_position + 5'd1;
    end
  end

  assign ok = (byte_position_next >= POS_FRAME_BYTES) && header_match_next
              && (running_crc_next == received_crc_next);

  assign result_valid           = beat && last_byte;
  assign result.frame_ok        = ok;
  assign result.linear_bits     = ok ? linear_hold_next : 32'd0;
  assign result.angular_bits    = ok ? angular_hold_next : 32'd0;
  assign result.drive_mode      = ok ? mode_hold_next : 8'd0;
  assign result.sequence_number = ok ? sequence_hold_next : 8'd0;

  always_ff @(posedge clk) begin
    if (rst || (beat && last_byte)) begin
      byte_position <= 5'd0;
      running_crc   <= CRC_INIT;
      header_match  <= 1'b1;
      linear_hold   <= 32'd0;
      angular_hold  <= 32'd0;
      mode_hold     <= 8'd0;
      sequence_hold <= 8'd0;
      received_crc  <= 16'd0;
    end else if (beat) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      header_match  <= header_match_next;
      linear_hold   <= linear_hold_next;
      angular_hold  <= angular_hold_next;
      mode_hold     <= mode_hold_next;
      sequence_hold <= sequence_hold_next;
      received_crc  <= received_crc_next;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mfd_skid.sv
// result register with one skid entry
`default_nettype none
module mfd_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire mfd_pkg::result_t  push_data,
  output logic                   can_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mfd_pkg::result_t       out_data
);
  import mfd_pkg::*;

  result_t main_data;
  result_t skid_data;
  logic    main_valid;
  logic    skid_valid;
  logic    pop;

  assign can_take  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        main_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/motion_frame_decoder_crc16.sv
// top level of the motion frame decoder with crc-16 check
//
//  channel  dir  fields                                            beat
//  in_ch    in   data_byte, last_byte                              valid && ready
//  out_ch   out  frame_ok, linear_bits, angular_bits,              valid && ready
//                drive_mode, sequence_number
//  cfg      in   cfg_we, cfg_index, cfg_data                       cfg_we
//
// one byte per ready cycle; the eight crc shift steps unroll into a shallow xor network
// a result reaches the output register or skid entry the cycle after its last byte
// in_ch.ready drops only while both the output register and the skid entry hold results
// rst is synchronous: registers go to their reset values, no clearing pass
`default_nettype none
module motion_frame_decoder_crc16 (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [mfd_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  wire logic [mfd_pkg::CfgDataWidth-1:0]     cfg_data,
  mfd_in_if.sink                                    in_ch,
  mfd_out_if.source                                 out_ch
);
  import mfd_pkg::*;

  cfg_t    cfg;
  logic    beat;
  logic    can_take;
  logic    result_valid;
  result_t result;
  result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first    <= SYNC_FIRST_RESET;
      cfg.sync_second   <= SYNC_SECOND_RESET;
      cfg.velocity_type <= VELOCITY_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:    cfg.sync_first    <= cfg_data;
        REG_SYNC_SECOND:   cfg.sync_second   <= cfg_data;
        REG_VELOCITY_TYPE: cfg.velocity_type <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = can_take;
  assign beat        = in_ch.valid && can_take;

  mfd_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .data_byte    (in_ch.data_byte),
    .last_byte    (in_ch.last_byte),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

  mfd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.frame_ok        = out_data.frame_ok;
  assign out_ch.linear_bits     = out_data.linear_bits;
  assign out_ch.angular_bits    = out_data.angular_bits;
  assign out_ch.drive_mode      = out_data.drive_mode;
  assign out_ch.sequence_number = out_data.sequence_number;
endmodule
`default_nettype wire

FILE: bench/motion_frame_decoder_crc16_checker.sv
// checker for the motion frame decoder: tracks frames, predicts decoded results, compares them
`timescale 1ns / 1ps
module motion_frame_decoder_crc16_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [mfd_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  wire logic [mfd_pkg::CfgDataWidth-1:0]     cfg_data,
  mfd_in_if                                         in_ch,
  mfd_out_if                                        out_ch,
  output int                                        fail_count,
  output int                                        pending,
  output int                                        frames_checked,
  output int                                        frames_good
);
  import mfd_pkg::*;

  localparam int LinearFirst = 4;
  localparam int LinearLast  = 7;
  localparam int AngularLast = 11;
  localparam int ModePos     = 12;
  localparam int SeqPos      = 13;
  localparam int CrcLowPos   = 14;
  localparam int CrcHighPos  = 15;

  logic [7:0]  want_sync_first;
  logic [7:0]  want_sync_second;
  logic [7:0]  want_type;

  logic [4:0]  frame_pos;
  logic [15:0] crc_acc;
  logic        header_good;
  logic [31:0] linear_acc;
  logic [31:0] angular_acc;
  logic [7:0]  mode_acc;
  logic [7:0]  seq_acc;
  logic [15:0] crc_rx;

  result_t     decoded_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
    frames_checked = 0;
    frames_good = 0;
  end

  function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = {1'b0, r[15:1]} ^ CRC_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  task automatic clear_frame();
    frame_pos = '0;
    crc_acc = CRC_INIT;
    header_good = 1'b1;
    linear_acc = '0;
    angular_acc = '0;
    mode_acc = '0;
    seq_acc = '0;
    crc_rx = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    int      p;
    logic    ok;
    result_t res;
    p = frame_pos;
    if (frame_pos < POS_FRAME_BYTES) begin
      if (frame_pos == POS_SYNC_FIRST && b != want_sync_first) header_good = 1'b0;
      if (frame_pos == POS_SYNC_SECOND && b != want_sync_second) header_good = 1'b0;
      if (frame_pos == POS_TYPE && b != want_type) header_good = 1'b0;
      if (frame_pos >= POS_CRC_START && frame_pos <= POS_CRC_END) begin
        crc_acc = modbus_crc_next(crc_acc, b);
      end
      if (p >= LinearFirst && p <= LinearLast) begin
        linear_acc[8*(p-LinearFirst) +: 8] = b;
      end else if (p > LinearLast && p <= AngularLast) begin
        angular_acc[8*(p-LinearLast-1) +: 8] = b;
      end else if (p == ModePos) begin
        mode_acc = b;
      end else if (p == SeqPos) begin
        seq_acc = b;
      end else if (p == CrcLowPos) begin
        crc_rx[7:0] = b;
      end else if (p == CrcHighPos) begin
        crc_rx[15:8] = b;
      end
      frame_pos = frame_pos + 5'd1;
    end
    if (fin) begin
      ok = (frame_pos == POS_FRAME_BYTES) && header_good && (crc_acc == crc_rx);
      res.frame_ok        = ok;
      res.linear_bits     = ok ? linear_acc : '0;
      res.angular_bits    = ok ? angular_acc : '0;
      res.drive_mode      = ok ? mode_acc : '0;
      res.sequence_number = ok ? seq_acc : '0;
      decoded_q.push_back(res);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp;
    if (rst) begin
      want_sync_first = SYNC_FIRST_RESET;
      want_sync_second = SYNC_SECOND_RESET;
      want_type = VELOCITY_TYPE_RESET;
      clear_frame();
      decoded_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        frames_checked++;
        if (decoded_q.size() == 0) begin
          $error("result beat with no frame outstanding: frame_ok %0b", out_ch.frame_ok);
          fail_count++;
        end else begin
          exp = decoded_q.pop_front();
          if (exp.frame_ok) frames_good++;
          check_field("frame_ok", 32'(exp.frame_ok), 32'(out_ch.frame_ok));
          check_field("linear_bits", exp.linear_bits, out_ch.linear_bits);
          check_field("angular_bits", exp.angular_bits, out_ch.angular_bits);
          check_field("drive_mode", 32'(exp.drive_mode), 32'(out_ch.drive_mode));
          check_field("sequence_number", 32'(exp.sequence_number),
                      32'(out_ch.sequence_number));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        absorb_byte(in_ch.data_byte, in_ch.last_byte);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_FIRST: begin
            want_sync_first = cfg_data;
          end
          REG_SYNC_SECOND: begin
            want_sync_second = cfg_data;
          end
          REG_VELOCITY_TYPE: begin
            want_type = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    pending = decoded_q.size();
  end

endmodule

FILE: bench/motion_frame_decoder_crc16_tb.sv
// testbench top for the motion frame decoder: clock, reset, frame stimulus and verdict
`timescale 1ns / 1ps
module motion_frame_decoder_crc16_tb;
  import mfd_pkg::*;

  localparam int IdleLimit   = 3000;
  localparam int HoldCycles  = 400;
  localparam int PhaseBytes  = 180;
  localparam int CrcLowPos   = 14;
  localparam int CrcHighPos  = 15;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SQUARE} rx_mode_e;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  logic hold_req;

  int fail_count;
  int pending;
  int frames_checked;
  int frames_good;

  int burst_left;
  int bytes_sent;
  int frames_sent;
  int settings_used;
  int idle_cycles;

  logic [7:0] cur_sync_first;
  logic [7:0] cur_sync_second;
  logic [7:0] cur_type;
  logic [7:0] fbuf [0:31];

  mfd_in_if  in_ch ();
  mfd_out_if out_ch ();

  motion_frame_decoder_crc16 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  motion_frame_decoder_crc16_checker mon (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .frames_checked (frames_checked),
    .frames_good    (frames_good)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no beat for %0d cycles", idle_cycles);
        $display("motion_frame_decoder_crc16 test failed");
        $finish;
      end
    end
  end

  // result receiver with its own stall pattern and one long hold-off on request
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       tick;
    out_ch.ready = 1'b0;
    mode = RX_ALWAYS;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS: begin
            out_ch.ready <= 1'b1;
          end
          RX_COIN: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
          RX_MOSTLY: begin
            out_ch.ready <= ($urandom_range(0, 9) != 0);
          end
          default: begin
            out_ch.ready <= ((tick % 32) < 16);
          end
        endcase
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic fin);
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'($urandom);
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      put_byte(fbuf[i], i == len - 1);
    end
    frames_sent++;
  endtask

  function automatic void seal_crc();
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = POS_CRC_START; i <= POS_CRC_END; i++) begin
      crc ^= {8'h00, fbuf[i]};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    fbuf[CrcLowPos] = crc[7:0];
    fbuf[CrcHighPos] = crc[15:8];
  endfunction

  function automatic void build_frame(input fill_e fill);
    fbuf[POS_SYNC_FIRST] = cur_sync_first;
    fbuf[POS_SYNC_SECOND] = cur_sync_second;
    fbuf[POS_TYPE] = cur_type;
    for (int i = POS_TYPE + 1; i <= POS_CRC_END; i++) begin
      case (fill)
        FILL_ZERO: fbuf[i] = 8'h00;
        FILL_ONES: fbuf[i] = 8'hFF;
        default:   fbuf[i] = 8'($urandom);
      endcase
    end
    seal_crc();
  endfunction

  task automatic write_regs(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] ty);
    cfg_we <= 1'b1;
    cfg_index <= REG_SYNC_FIRST;
    cfg_data <= s0;
    @(negedge clk);
    cfg_index <= REG_SYNC_SECOND;
    cfg_data <= s1;
    @(negedge clk);
    cfg_index <= REG_VELOCITY_TYPE;
    cfg_data <= ty;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_sync_first = s0;
    cur_sync_second = s1;
    cur_type = ty;
    settings_used++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input int target);
    int    stop;
    int    roll;
    int    len;
    int    hit;
    fill_e fill;
    stop = bytes_sent + target;
    while (bytes_sent < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) fill = FILL_ZERO;
      else if (roll < 8) fill = FILL_ONES;
      else fill = FILL_RANDOM;
      build_frame(fill);
      len = 16;
      if (roll >= 60 && roll < 70) begin
        len = 16 + $urandom_range(1, 6);
        for (int i = 16; i < len; i++) fbuf[i] = 8'($urandom);
      end else if (roll >= 70 && roll < 78) begin
        hit = $urandom_range(0, 15);
        fbuf[hit] = fbuf[hit] ^ 8'($urandom_range(1, 255));
      end else if (roll >= 78 && roll < 86) begin
        len = $urandom_range(1, 15);
      end else if (roll >= 86 && roll < 93) begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) fbuf[i] = 8'($urandom);
      end else if (roll >= 93) begin
        // wrong type byte under a crc that matches it
        fbuf[POS_TYPE] = cur_type ^ 8'($urandom_range(1, 255));
        seal_crc();
      end
      send_frame(len);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    frames_sent = 0;
    settings_used = 1;
    idle_cycles = 0;
    cur_sync_first = SYNC_FIRST_RESET;
    cur_sync_second = SYNC_SECOND_RESET;
    cur_type = VELOCITY_TYPE_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // one-byte frame
    fbuf[0] = cur_sync_first;
    send_frame(1);
    // all-ones payload followed by bytes past the sixteenth
    build_frame(FILL_ONES);
    fbuf[16] = 8'h00;
    fbuf[17] = 8'hFF;
    send_frame(18);
    // zero payload, type byte wrong, crc consistent
    build_frame(FILL_ZERO);
    fbuf[POS_TYPE] = ~cur_type;
    seal_crc();
    send_frame(16);
    run_random(PhaseBytes);

    for (int ph = 1; ph <= 4; ph++) begin
      settle();
      case (ph)
        1: write_regs(8'h00, 8'h00, 8'h00);
        2: write_regs(8'hFF, 8'hFF, 8'hFF);
        default: write_regs(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      if (ph == 2) begin
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) begin
          fbuf[0] = 8'($urandom);
          send_frame(1);
        end
      end
      run_random(PhaseBytes);
    end
    settle();

    $display("sent %0d bytes in %0d frames under %0d register settings",
             bytes_sent, frames_sent, settings_used);
    $display("checked %0d decoded frames, %0d of them good", frames_checked, frames_good);
    if (fail_count == 0 && pending == 0) begin
      $display("motion_frame_decoder_crc16 test passed");
    end else begin
      $display("motion_frame_decoder_crc16 test failed");
    end
    $finish;
  end

endmodule
